FILE: rtl/five_bar_arm_inverse_kinematics_defines.svh
// ----------------------------------------------------------------------------
// five bar arm inverse kinematics assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef FIVE_BAR_ARM_INVERSE_KINEMATICS_DEFINES_SVH
`define FIVE_BAR_ARM_INVERSE_KINEMATICS_DEFINES_SVH

// property checked outside reset
`define FBIK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define FBIK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/fbik_pkg.sv
// ----------------------------------------------------------------------------
// fbik_pkg
// widths, constants and codes of the five bar arm inverse kinematics block
// ----------------------------------------------------------------------------
package fbik_pkg;

   localparam int ARM_W  = 15;
   localparam int POS_W  = 16;
   localparam int DX_W   = 18;
   localparam int U_W    = 36;
   localparam int N_W    = 36;
   localparam int H_W    = 32;
   localparam int E_W    = 54;
   localparam int Z_W    = 28;
   localparam int ANG_W  = 19;
   localparam int ZERO_W = 17;
   localparam int CNT_W  = 15;
   localparam int CSR_W  = 17;
   localparam int IDX_W  = 3;

   localparam int SQRT_STEPS   = 32;
   localparam int CORDIC_STEPS = 23;
   // front 4, root, product, combine, magnitude, normalize 3, quadrant, cordic, round
   localparam int JNT_LAT = 4 + SQRT_STEPS + 2 + 1 + 3 + 1 + CORDIC_STEPS + 1;
   localparam int RSP_LAT = JNT_LAT + 2;

   localparam logic signed [Z_W-1:0] DEG180 = 28'sd11796480;
   localparam int COUNTS_PER_DEG = 2970 / 90;

   localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      28'sd2949120, 28'sd1740967, 28'sd919879, 28'sd466945, 28'sd234379,
      28'sd117304, 28'sd58666, 28'sd29335, 28'sd14668, 28'sd7334, 28'sd3667,
      28'sd1833, 28'sd917, 28'sd458, 28'sd229, 28'sd115, 28'sd57, 28'sd29,
      28'sd14, 28'sd7, 28'sd4, 28'sd2, 28'sd1
   };

   typedef enum logic [IDX_W-1:0] {
      CSR_HALF_SPACING = 3'd0,
      CSR_JOINT_HEIGHT = 3'd1,
      CSR_UPPER_ARM    = 3'd2,
      CSR_LOWER_ARM    = 3'd3,
      CSR_LEFT_ZERO    = 3'd4,
      CSR_RIGHT_ZERO   = 3'd5
   } csr_index_type;

endpackage

FILE: rtl/fbik_joint.sv
// ----------------------------------------------------------------------------
// fbik_joint
// pipelined angle of one shoulder joint: circle intersection, integer root,
// normalization and vectoring cordic, rounded to Q11.7 degrees
// ----------------------------------------------------------------------------
module fbik_joint (
   input  logic                                 clock,
   input  logic                                 is_left,
   input  logic signed [fbik_pkg::DX_W-1:0]     dx_in,
   input  logic signed [fbik_pkg::DX_W-1:0]     dy_in,
   input  logic        [fbik_pkg::ARM_W-1:0]    upper_len,
   input  logic        [fbik_pkg::ARM_W-1:0]    lower_len,
   output logic signed [fbik_pkg::ANG_W-1:0]    angle_out,
   output logic                                 reach_ok
);

   localparam int DXW = fbik_pkg::DX_W;
   localparam int AW  = fbik_pkg::ARM_W;
   localparam int UW  = fbik_pkg::U_W;
   localparam int NW  = fbik_pkg::N_W;
   localparam int HW  = fbik_pkg::H_W;
   localparam int EW  = fbik_pkg::E_W;
   localparam int ZW  = fbik_pkg::Z_W;
   localparam int SQ  = fbik_pkg::SQRT_STEPS;
   localparam int CS  = fbik_pkg::CORDIC_STEPS;
   localparam int PW  = 2 * HW;
   localparam int RW  = HW + 2;
   localparam int OK_LEN   = fbik_pkg::JNT_LAT - 3 + 1;
   localparam int ZERO_LEN = CS + 5;

   typedef struct packed {
      logic signed [EW-1:0] x;
      logic signed [EW-1:0] y;
      logic        [EW-1:0] m;
   } norm_type;

   function automatic norm_type norm_step(norm_type v, int b);
      norm_type r;
      r = v;
      if ((v.m >> (EW - 4 - b)) == '0) begin
         r.x = v.x <<< b;
         r.y = v.y <<< b;
         r.m = v.m << b;
      end
      return r;
   endfunction

   // stage 1: squares
   logic signed [2*DXW-1:0] dxsq_s, dysq_s;
   logic        [AW:0]      asum;
   logic signed [AW+1:0]    adiff;
   logic signed [2*AW+3:0]  sm_s;
   logic signed [DXW-1:0]   dx1_ff, dy1_ff;
   logic        [UW-1:0]    dxsq1_ff, dysq1_ff;
   logic        [2*AW+1:0]  sp1_ff;
   logic        [2*AW:0]    sm1_ff;
   logic        [2*AW-1:0]  a1sq1_ff, a2sq1_ff;

   assign dxsq_s = dx_in * dx_in;
   assign dysq_s = dy_in * dy_in;
   assign asum   = {1'b0, upper_len} + {1'b0, lower_len};
   assign adiff  = $signed({2'b00, upper_len}) - $signed({2'b00, lower_len});
   assign sm_s   = adiff * adiff;

   always_ff @(posedge clock) begin
      dx1_ff   <= dx_in;
      dy1_ff   <= dy_in;
      dxsq1_ff <= $unsigned(dxsq_s);
      dysq1_ff <= $unsigned(dysq_s);
      sp1_ff   <= asum * asum;
      sm1_ff   <= sm_s[2*AW:0];
      a1sq1_ff <= upper_len * upper_len;
      a2sq1_ff <= lower_len * lower_len;
   end

   // stage 2: distance squared
   logic signed [DXW-1:0]  dx2_ff, dy2_ff;
   logic        [UW-1:0]   u2_ff;
   logic signed [2*AW:0]   d2_ff;
   logic        [2*AW+1:0] sp2_ff;
   logic        [2*AW:0]   sm2_ff;

   always_ff @(posedge clock) begin
      dx2_ff <= dx1_ff;
      dy2_ff <= dy1_ff;
      u2_ff  <= dxsq1_ff + dysq1_ff;
      d2_ff  <= $signed({1'b0, a1sq1_ff}) - $signed({1'b0, a2sq1_ff});
      sp2_ff <= sp1_ff;
      sm2_ff <= sm1_ff;
   end

   // stage 3: reach test and root factors
   logic                   ok3;
   logic signed [UW:0]     n3_s;
   logic signed [DXW-1:0]  dx3_ff, dy3_ff;
   logic        [HW-1:0]   pa3_ff, pb3_ff;
   logic signed [NW-1:0]   n3_ff;
   logic                   ok_ff [OK_LEN];

   assign ok3  = (u2_ff != '0) && (u2_ff <= UW'(sp2_ff)) && (u2_ff >= UW'(sm2_ff));
   assign n3_s = $signed({1'b0, u2_ff}) + (UW+1)'(d2_ff);

   always_ff @(posedge clock) begin
      dx3_ff <= dx2_ff;
      dy3_ff <= dy2_ff;
      pa3_ff <= sp2_ff[HW-1:0] - u2_ff[HW-1:0];
      pb3_ff <= u2_ff[HW-1:0] - HW'(sm2_ff);
      n3_ff  <= n3_s[NW-1:0];
   end

   always_ff @(posedge clock) begin
      ok_ff[0] <= ok3;
      for (int k = 1; k < OK_LEN; k++) begin
         ok_ff[k] <= ok_ff[k-1];
      end
   end

   // stage 4: root operand and dot products
   logic        [PW-1:0]  prod4_ff;
   logic signed [EW-1:0]  dxn4_ff, dyn4_ff;
   logic signed [DXW-1:0] dx4_ff, dy4_ff;

   always_ff @(posedge clock) begin
      prod4_ff <= pa3_ff * pb3_ff;
      dxn4_ff  <= dx3_ff * n3_ff;
      dyn4_ff  <= dy3_ff * n3_ff;
      dx4_ff   <= dx3_ff;
      dy4_ff   <= dy3_ff;
   end

   // integer square root, one result bit per stage
   logic        [RW-1:0]  sq_rem_ff  [SQ];
   logic        [HW-1:0]  sq_root_ff [SQ];
   logic        [PW-1:0]  sq_rad_ff  [SQ];
   logic signed [DXW-1:0] dl_dx_ff   [SQ];
   logic signed [DXW-1:0] dl_dy_ff   [SQ];
   logic signed [EW-1:0]  dl_dxn_ff  [SQ];
   logic signed [EW-1:0]  dl_dyn_ff  [SQ];

   for (genvar j = 0; j < SQ; j++) begin : g_sqrt
      logic [RW-1:0] rem_src, rem_t, trial;
      logic [HW-1:0] root_src;
      logic [PW-1:0] rad_src;
      logic          ge;
      if (j == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = prod4_ff;
      end else begin : g_next
         assign rem_src  = sq_rem_ff[j-1];
         assign root_src = sq_root_ff[j-1];
         assign rad_src  = sq_rad_ff[j-1];
      end
      assign rem_t = {rem_src[RW-3:0], rad_src[PW-1:PW-2]};
      assign trial = {root_src, 2'b01};
      assign ge    = rem_t >= trial;
      always_ff @(posedge clock) begin
         sq_rem_ff[j]  <= ge ? rem_t - trial : rem_t;
         sq_root_ff[j] <= {root_src[HW-2:0], ge};
         sq_rad_ff[j]  <= {rad_src[PW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      dl_dx_ff[0]  <= dx4_ff;
      dl_dy_ff[0]  <= dy4_ff;
      dl_dxn_ff[0] <= dxn4_ff;
      dl_dyn_ff[0] <= dyn4_ff;
      for (int k = 1; k < SQ; k++) begin
         dl_dx_ff[k]  <= dl_dx_ff[k-1];
         dl_dy_ff[k]  <= dl_dy_ff[k-1];
         dl_dxn_ff[k] <= dl_dxn_ff[k-1];
         dl_dyn_ff[k] <= dl_dyn_ff[k-1];
      end
   end

   // height products
   logic signed [HW:0]       h_s;
   logic signed [DXW+HW:0]   dxh_ff, dyh_ff;
   logic signed [EW-1:0]     dxn_ff, dyn_ff;

   assign h_s = $signed({1'b0, sq_root_ff[SQ-1]});

   always_ff @(posedge clock) begin
      dxh_ff <= dl_dx_ff[SQ-1] * h_s;
      dyh_ff <= dl_dy_ff[SQ-1] * h_s;
      dxn_ff <= dl_dxn_ff[SQ-1];
      dyn_ff <= dl_dyn_ff[SQ-1];
   end

   // outer elbow vector
   logic signed [EW-1:0] ex_ff, ey_ff;

   always_ff @(posedge clock) begin
      if (is_left) begin
         ex_ff <= dxn_ff - EW'(dyh_ff);
         ey_ff <= dyn_ff + EW'(dxh_ff);
      end else begin
         ex_ff <= dxn_ff + EW'(dyh_ff);
         ey_ff <= dyn_ff - EW'(dxh_ff);
      end
   end

   // magnitude bound and normalization
   logic     [EW-1:0] ax, ay;
   norm_type          nrm_ff [4];
   logic              zero_ff [ZERO_LEN];

   assign ax = ex_ff[EW-1] ? $unsigned(-ex_ff) : $unsigned(ex_ff);
   assign ay = ey_ff[EW-1] ? $unsigned(-ey_ff) : $unsigned(ey_ff);

   always_ff @(posedge clock) begin
      nrm_ff[0].x <= ex_ff;
      nrm_ff[0].y <= ey_ff;
      nrm_ff[0].m <= ax | ay;
      nrm_ff[1]   <= norm_step(norm_step(nrm_ff[0], 32), 16);
      nrm_ff[2]   <= norm_step(norm_step(nrm_ff[1], 8), 4);
      nrm_ff[3]   <= norm_step(norm_step(nrm_ff[2], 2), 1);
   end

   always_ff @(posedge clock) begin
      zero_ff[0] <= (ax | ay) == '0;
      for (int k = 1; k < ZERO_LEN; k++) begin
         zero_ff[k] <= zero_ff[k-1];
      end
   end

   // quadrant fold and vectoring cordic
   logic signed [EW-1:0] cx_ff [CS+1];
   logic signed [EW-1:0] cy_ff [CS+1];
   logic signed [ZW-1:0] cz_ff [CS+1];

   always_ff @(posedge clock) begin
      if (nrm_ff[3].x[EW-1]) begin
         cx_ff[0] <= -nrm_ff[3].x;
         cy_ff[0] <= -nrm_ff[3].y;
         cz_ff[0] <= nrm_ff[3].y[EW-1] ? -fbik_pkg::DEG180 : fbik_pkg::DEG180;
      end else begin
         cx_ff[0] <= nrm_ff[3].x;
         cy_ff[0] <= nrm_ff[3].y;
         cz_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < CS; i++) begin : g_cordic
      logic signed [EW-1:0] xs, ys;
      assign xs = cx_ff[i] >>> i;
      assign ys = cy_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (cy_ff[i] > 0) begin
            cx_ff[i+1] <= cx_ff[i] + ys;
            cy_ff[i+1] <= cy_ff[i] - xs;
            cz_ff[i+1] <= cz_ff[i] + fbik_pkg::ATAN_TAB[i];
         end else begin
            cx_ff[i+1] <= cx_ff[i] - ys;
            cy_ff[i+1] <= cy_ff[i] + xs;
            cz_ff[i+1] <= cz_ff[i] - fbik_pkg::ATAN_TAB[i];
         end
      end
   end

   // mirror and round to Q11.7
   logic signed [ZW-1:0] zsel, amir, arnd;
   logic signed [fbik_pkg::ANG_W-1:0] angle_ff;

   assign zsel = zero_ff[ZERO_LEN-1] ? '0 : cz_ff[CS];
   assign amir = is_left ? fbik_pkg::DEG180 - zsel : zsel;
   assign arnd = (amir + ZW'(256)) >>> 9;

   always_ff @(posedge clock) begin
      angle_ff <= arnd[fbik_pkg::ANG_W-1:0];
   end

   assign angle_out = angle_ff;
   assign reach_ok  = ok_ff[OK_LEN-1];

endmodule

FILE: rtl/five_bar_arm_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// five_bar_arm_inverse_kinematics
// Turns a pen target point into the encoder targets of both motors of a
// symmetric five-bar plotter. One request is taken on every clock (busy stays
// low) and its result appears on the rsp_ ports for one cycle, in request
// order. Each joint path holds a 32-stage integer square root and a
// 23-stage cordic.
// A target out of reach or on a joint gives zero counts with rsp_unreachable
// set. Write the csr_ registers only while no request is in flight.
// ----------------------------------------------------------------------------
module five_bar_arm_inverse_kinematics (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [fbik_pkg::POS_W-1:0]    req_target_x,
   input  logic signed [fbik_pkg::POS_W-1:0]    req_target_y,
   output logic                                 rsp_valid,
   output logic signed [fbik_pkg::CNT_W-1:0]    rsp_left_counts,
   output logic signed [fbik_pkg::CNT_W-1:0]    rsp_right_counts,
   output logic                                 rsp_unreachable,
   input  logic                                 csr_write_enable,
   input  logic        [fbik_pkg::IDX_W-1:0]    csr_index,
   input  logic        [fbik_pkg::CSR_W-1:0]    csr_write_data
);

   localparam int DXW  = fbik_pkg::DX_W;
   localparam int AW   = fbik_pkg::ARM_W;
   localparam int PSW  = fbik_pkg::POS_W;
   localparam int ANW  = fbik_pkg::ANG_W;
   localparam int ZRW  = fbik_pkg::ZERO_W;
   localparam int CW   = fbik_pkg::CNT_W;
   localparam int LAT  = fbik_pkg::JNT_LAT;
   localparam int DW   = ANW + 1;
   localparam int SW   = DW + 6;

   function automatic logic signed [CW-1:0] to_counts(
      logic signed [ANW-1:0] ang,
      logic signed [ZRW-1:0] zero
   );
      logic signed [DW-1:0] diff;
      logic signed [SW-1:0] scaled;
      logic signed [SW-1:0] rnd;
      logic signed [CW-1:0] res;
      diff   = DW'(ang) - DW'(zero);
      scaled = SW'(diff) * SW'(fbik_pkg::COUNTS_PER_DEG);
      rnd    = (scaled + SW'(64)) >>> 7;
      if (rnd > SW'(16383)) begin
         res = 15'sd16383;
      end else if (rnd < -SW'(16384)) begin
         res = -15'sd16384;
      end else begin
         res = rnd[CW-1:0];
      end
      return res;
   endfunction

   // configuration registers
   logic        [AW-1:0]  half_spacing_ff, upper_len_ff, lower_len_ff;
   logic signed [PSW-1:0] joint_height_ff;
   logic signed [ZRW-1:0] left_zero_ff, right_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_spacing_ff <= 15'd896;
         joint_height_ff <= -16'sd2560;
         upper_len_ff    <= 15'd2816;
         lower_len_ff    <= 15'd3584;
         left_zero_ff    <= 17'sd3645;
         right_zero_ff   <= 17'sd3645;
      end else if (csr_write_enable) begin
         unique case (fbik_pkg::csr_index_type'(csr_index))
            fbik_pkg::CSR_HALF_SPACING: half_spacing_ff <= csr_write_data[AW-1:0];
            fbik_pkg::CSR_JOINT_HEIGHT: joint_height_ff <= csr_write_data[PSW-1:0];
            fbik_pkg::CSR_UPPER_ARM:    upper_len_ff    <= csr_write_data[AW-1:0];
            fbik_pkg::CSR_LOWER_ARM:    lower_len_ff    <= csr_write_data[AW-1:0];
            fbik_pkg::CSR_LEFT_ZERO:    left_zero_ff    <= csr_write_data;
            fbik_pkg::CSR_RIGHT_ZERO:   right_zero_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // request stage: offsets from both joints
   logic                  accept;
   logic                  valid_ff [LAT+1];
   logic signed [DXW-1:0] dxl_ff, dxr_ff, dy_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      dxl_ff <= DXW'(req_target_x) + $signed({3'b000, half_spacing_ff});
      dxr_ff <= DXW'(req_target_x) - $signed({3'b000, half_spacing_ff});
      dy_ff  <= DXW'(req_target_y) - DXW'(joint_height_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAT; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= accept;
         for (int k = 1; k <= LAT; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   logic signed [ANW-1:0] left_angle, right_angle;
   logic                  left_ok, right_ok;

   fbik_joint u_left (
      .clock     (clock),
      .is_left   (1'b1),
      .dx_in     (dxl_ff),
      .dy_in     (dy_ff),
      .upper_len (upper_len_ff),
      .lower_len (lower_len_ff),
      .angle_out (left_angle),
      .reach_ok  (left_ok)
   );

   fbik_joint u_right (
      .clock     (clock),
      .is_left   (1'b0),
      .dx_in     (dxr_ff),
      .dy_in     (dy_ff),
      .upper_len (upper_len_ff),
      .lower_len (lower_len_ff),
      .angle_out (right_angle),
      .reach_ok  (right_ok)
   );

   // response register
   logic                 rsp_valid_ff, unreach_ff;
   logic signed [CW-1:0] left_cnt_ff, right_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff[LAT];
      end
   end

   always_ff @(posedge clock) begin
      if (left_ok && right_ok) begin
         left_cnt_ff  <= to_counts(left_angle, left_zero_ff);
         right_cnt_ff <= to_counts(right_angle, right_zero_ff);
         unreach_ff   <= 1'b0;
      end else begin
         left_cnt_ff  <= '0;
         right_cnt_ff <= '0;
         unreach_ff   <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_counts  = left_cnt_ff;
   assign rsp_right_counts = right_cnt_ff;
   assign rsp_unreachable  = unreach_ff;

endmodule

FILE: rtl/fbik_checker.sv
// ----------------------------------------------------------------------------
// fbik_checker
// port level checks of the five bar arm inverse kinematics block
// ----------------------------------------------------------------------------
`include "five_bar_arm_inverse_kinematics_defines.svh"

module fbik_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic signed [fbik_pkg::CNT_W-1:0]  rsp_left_counts,
   input logic signed [fbik_pkg::CNT_W-1:0]  rsp_right_counts,
   input logic                               rsp_unreachable
);

   // every response comes from an earlier accepted request
   `FBIK_ASSERT(a_rsp_from_req, clock, reset, rsp_valid |-> $past(start && !busy, fbik_pkg::RSP_LAT), "response without request")

   // unreachable targets carry zero counts
   `FBIK_ASSERT(a_unreach_zero, clock, reset, (rsp_valid && rsp_unreachable) |-> (rsp_left_counts == '0 && rsp_right_counts == '0), "unreachable with counts")

   // fully pipelined: always ready
   `FBIK_ASSERT_ALWAYS(a_never_busy, clock, !busy, "busy raised")

endmodule

bind five_bar_arm_inverse_kinematics fbik_checker u_fbik_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_left_counts  (rsp_left_counts),
   .rsp_right_counts (rsp_right_counts),
   .rsp_unreachable  (rsp_unreachable)
);
